>>> hw/rtl/particle_set_pose_statistics_core_macros.svh
// assertion helpers used by the core rtl
`ifndef PARTICLE_SET_POSE_STATISTICS_CORE_MACROS_SVH
`define PARTICLE_SET_POSE_STATISTICS_CORE_MACROS_SVH

// property that must hold at every edge outside reset
`define PSPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define PSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/psps_pkg.sv
`timescale 1ns / 1ps
package psps_pkg;

   // default store depth
   localparam int MAX_PARTICLES_DEF = 1024;

   // datapath widths
   localparam int POS_W  = 32;
   localparam int HDG_W  = 16;
   localparam int ACC_W  = 128;
   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;
   localparam int TT_W   = 64;

   typedef struct packed {
      logic signed [31:0] particle_x;
      logic signed [31:0] particle_y;
      logic signed [15:0] particle_heading;
      logic               last_particle;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] mean_x;
      logic signed [31:0] mean_y;
      logic signed [15:0] mean_heading;
      logic [63:0]        var_x;
      logic [63:0]        var_y;
      logic [30:0]        var_heading;
      logic signed [63:0] cov_xy;
      logic signed [47:0] cov_y_heading;
      logic signed [47:0] cov_x_heading;
      logic [1:0]         status;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FEW      = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DIV_MEAN,
      ST_PASS1,
      ST_PICK,
      ST_PASS2,
      ST_DIV_FINAL,
      ST_FINISH
   } state_type;

endpackage

>>> hw/rtl/particle_set_pose_statistics_core.sv
`timescale 1ns / 1ps
// after the last particle, four mean divisions and six final divisions run on one
// shift-subtract divider, and pass one and pass two multiply on one 33x33
// multiplier; throughput one particle per cycle while loading
// reset: synchronous, clears the sequencer, count, overflow flag and sums;
// the particle stores are not cleared
`include "particle_set_pose_statistics_core_macros.svh"
module particle_set_pose_statistics_core
   import psps_pkg::*;
#(
   parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
   localparam int AW     = $clog2(MAX_PARTICLES);
   localparam int SUM_W  = POS_W + CNT_W;
   localparam int HSUM_W = HDG_W + CNT_W;
   localparam int DCNT_W = $clog2(ACC_W + 2);

   localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_PARTICLES);
   localparam logic [CNT_W-1:0]  TWO_CNT = CNT_W'(2);
   localparam logic [DCNT_W-1:0] DIV_WB  = DCNT_W'(ACC_W + 1);

   // sub steps of one particle in a pass
   localparam logic [2:0] STEP_RD    = 3'd0;
   localparam logic [2:0] STEP_DEV   = 3'd1;
   localparam logic [2:0] STEP_MUL0  = 3'd2;
   localparam logic [2:0] STEP_ACC0  = 3'd3;
   localparam logic [2:0] STEP_LAST1 = 3'd6;
   localparam logic [2:0] STEP_LAST2 = 3'd5;

   // products of pass one
   localparam logic [2:0] K_SQ_X  = 3'd0;
   localparam logic [2:0] K_SQ_Y  = 3'd1;
   localparam logic [2:0] K_SQ_H  = 3'd2;
   localparam logic [2:0] K_SQ_HS = 3'd3;
   // products of pass two
   localparam logic [2:0] K_XY = 3'd0;
   localparam logic [2:0] K_YH = 3'd1;
   localparam logic [2:0] K_XH = 3'd2;

   // divider jobs
   localparam logic [2:0] JM_X    = 3'd0;
   localparam logic [2:0] JM_Y    = 3'd1;
   localparam logic [2:0] JM_H    = 3'd2;
   localparam logic [2:0] JM_HS   = 3'd3;
   localparam logic [2:0] JF_TT   = 3'd0;
   localparam logic [2:0] JF_XX   = 3'd1;
   localparam logic [2:0] JF_YY   = 3'd2;
   localparam logic [2:0] JF_XY   = 3'd3;
   localparam logic [2:0] JF_YH   = 3'd4;
   localparam logic [2:0] JF_XH   = 3'd5;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [HSUM_W-1:0] sum_h_ff, sum_h_in, sum_s_ff, sum_s_in;

   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [2:0]        step_ff, step_in;
   logic [2:0]        job_ff, job_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [ACC_W-1:0]  dq_ff, dq_in;
   logic [CNT_W-1:0]  dr_ff, dr_in;
   logic              dneg_ff, dneg_in;

   logic signed [31:0] mx_ff, mx_in, my_ff, my_in;
   logic signed [15:0] mh_ff, mh_in, mh2_ff, mh2_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [16:0] e1_ff, e1_in, e2_ff, e2_in;
   logic signed [15:0] dh_ff, dh_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic signed [ACC_W-1:0] xx_ff, xx_in, yy_ff, yy_in, xy_ff, xy_in;
   logic signed [ACC_W-1:0] yt_ff, yt_in, tx_ff, tx_in;
   logic signed [TT_W-1:0]  tt_ff, tt_in, tt2_ff, tt2_in;

   rsp_payload_type res_ff, res_in, rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // particle stores
   logic signed [31:0] store_x_mem [MAX_PARTICLES];
   logic signed [31:0] store_y_mem [MAX_PARTICLES];
   logic signed [15:0] store_h_mem [MAX_PARTICLES];
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic signed [15:0] rd_h_ff;

   // handshake and sequencing controls
   logic             req_acc, rsp_take, rsp_load, room, ovf_after;
   logic [CNT_W-1:0] cnt_after, last_idx;
   logic [2:0]       step_last, mul_k, acc_k;
   logic             in_pass, pass_end, div_wb, mem_wr, mem_rd;

   // shared unit operands
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [ACC_W-1:0] acc_sel, acc_sum, div_op;
   logic [CNT_W-1:0]        div_d;
   logic [CNT_W:0]          rem_sh;
   logic [ACC_W-1:0]        quo_s;
   logic [15:0]             h_shift;

   // signed quotient clamp to a width, result masked into 64 bits
   function automatic logic [63:0] sat_signed(input logic [ACC_W-1:0] q,
                                              input logic neg, input int w);
      logic [63:0] pos;
      logic [63:0] lim;
      logic [63:0] mask;
      logic [63:0] r;
      pos  = (64'd1 << (w - 1)) - 64'd1;
      lim  = neg ? pos + 64'd1 : pos;
      mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      r    = ((|q[ACC_W-1:64]) || (q[63:0] > lim)) ? lim : q[63:0];
      r    = neg ? (64'd0 - r) : r;
      return r & mask;
   endfunction

   assign req_acc   = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign room      = count_ff < MAX_CNT;
   assign cnt_after = room ? count_ff + 1'b1 : count_ff;
   assign ovf_after = ovf_ff || !room;
   assign last_idx  = count_ff - 1'b1;
   assign in_pass   = (state_ff == ST_PASS1) || (state_ff == ST_PASS2);
   assign step_last = (state_ff == ST_PASS1) ? STEP_LAST1 : STEP_LAST2;
   assign pass_end  = in_pass && (step_ff == step_last) && (idx_ff == last_idx);
   assign div_wb    = dcnt_ff == DIV_WB;
   assign mul_k     = step_ff - STEP_MUL0;
   assign acc_k     = step_ff - STEP_ACC0;
   assign mem_wr    = req_acc && room;
   assign mem_rd    = in_pass && (step_ff == STEP_RD);
   assign h_shift   = {~rd_h_ff[15], rd_h_ff[14:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_data.last_particle) begin
               state_in = (cnt_after < TWO_CNT) ? ST_FINISH : ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (div_wb && job_ff == JM_HS) state_in = ST_PASS1;
         end
         ST_PASS1: begin
            if (pass_end) state_in = ST_PICK;
         end
         ST_PICK: state_in = ST_PASS2;
         ST_PASS2: begin
            if (pass_end) state_in = ST_DIV_FINAL;
         end
         ST_DIV_FINAL: begin
            if (div_wb && job_ff == JF_XH) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_LOAD:   req_stall = 1'b0;
         ST_FINISH: rsp_load  = !rsp_valid_ff || !rsp_stall;
         default: begin
            req_stall = 1'b1;
            rsp_load  = 1'b0;
         end
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = dx_ff;
      mul_b = dx_ff;
      if (state_ff == ST_PASS1) begin
         unique case (mul_k)
            K_SQ_X:  begin mul_a = dx_ff; mul_b = dx_ff; end
            K_SQ_Y:  begin mul_a = dy_ff; mul_b = dy_ff; end
            K_SQ_H:  begin mul_a = MUL_W'(e1_ff); mul_b = MUL_W'(e1_ff); end
            K_SQ_HS: begin mul_a = MUL_W'(e2_ff); mul_b = MUL_W'(e2_ff); end
            default: begin mul_a = dx_ff; mul_b = dx_ff; end
         endcase
      end else begin
         unique case (mul_k)
            K_XY:    begin mul_a = dx_ff; mul_b = dy_ff; end
            K_YH:    begin mul_a = dy_ff; mul_b = MUL_W'(dh_ff); end
            K_XH:    begin mul_a = dx_ff; mul_b = MUL_W'(dh_ff); end
            default: begin mul_a = dx_ff; mul_b = dy_ff; end
         endcase
      end
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // accumulator select and the one wide adder
   always_comb begin
      acc_sel = xx_ff;
      if (state_ff == ST_PASS1) begin
         unique case (acc_k)
            K_SQ_X:  acc_sel = xx_ff;
            K_SQ_Y:  acc_sel = yy_ff;
            K_SQ_H:  acc_sel = ACC_W'(tt_ff);
            K_SQ_HS: acc_sel = ACC_W'(tt2_ff);
            default: acc_sel = xx_ff;
         endcase
      end else begin
         unique case (acc_k)
            K_XY:    acc_sel = xy_ff;
            K_YH:    acc_sel = yt_ff;
            K_XH:    acc_sel = tx_ff;
            default: acc_sel = xy_ff;
         endcase
      end
      acc_sum = acc_sel + ACC_W'(prod_ff);
   end

   // divider operand and divisor select
   always_comb begin
      div_op = ACC_W'(sum_x_ff);
      div_d  = count_ff;
      if (state_ff == ST_DIV_MEAN) begin
         unique case (job_ff)
            JM_X:    div_op = ACC_W'(sum_x_ff);
            JM_Y:    div_op = ACC_W'(sum_y_ff);
            JM_H:    div_op = ACC_W'(sum_h_ff);
            JM_HS:   div_op = ACC_W'(sum_s_ff);
            default: div_op = ACC_W'(sum_x_ff);
         endcase
      end else begin
         div_d = last_idx;
         unique case (job_ff)
            JF_TT:   div_op = ACC_W'(tt_ff);
            JF_XX:   div_op = xx_ff;
            JF_YY:   div_op = yy_ff;
            JF_XY:   div_op = xy_ff;
            JF_YH:   div_op = yt_ff;
            JF_XH:   div_op = tx_ff;
            default: div_op = ACC_W'(tt_ff);
         endcase
      end
      rem_sh = {dr_ff, dq_ff[ACC_W-1]};
      quo_s  = dneg_ff ? (ACC_W'(0) - dq_ff) : dq_ff;
   end

   // datapath next values
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      sum_h_in = sum_h_ff;
      sum_s_in = sum_s_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      dcnt_in  = dcnt_ff;
      dq_in    = dq_ff;
      dr_in    = dr_ff;
      dneg_in  = dneg_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      mh_in    = mh_ff;
      mh2_in   = mh2_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      e1_in    = e1_ff;
      e2_in    = e2_ff;
      dh_in    = dh_ff;
      xx_in    = xx_ff;
      yy_in    = yy_ff;
      xy_in    = xy_ff;
      yt_in    = yt_ff;
      tx_in    = tx_ff;
      tt_in    = tt_ff;
      tt2_in   = tt2_ff;
      res_in   = res_ff;
      rsp_in   = rsp_ff;

      unique case (state_ff)
         // take particles and accumulate sums
         ST_LOAD: begin
            if (req_acc) begin
               count_in = cnt_after;
               ovf_in   = ovf_after;
               if (room) begin
                  sum_x_in = sum_x_ff + SUM_W'(req_data.particle_x);
                  sum_y_in = sum_y_ff + SUM_W'(req_data.particle_y);
                  sum_h_in = sum_h_ff + HSUM_W'(req_data.particle_heading);
                  sum_s_in = sum_s_ff + HSUM_W'($signed({~req_data.particle_heading[15],
                                                         req_data.particle_heading[14:0]}));
               end
               if (req_data.last_particle) begin
                  job_in  = JM_X;
                  dcnt_in = '0;
                  if (cnt_after < TWO_CNT) begin
                     res_in        = '0;
                     res_in.status = STATUS_FEW;
                  end else begin
                     res_in.status = ovf_after ? STATUS_OVERFLOW : STATUS_OK;
                  end
               end
            end
         end
         // shift-subtract divider shared by all divisions
         ST_DIV_MEAN, ST_DIV_FINAL: begin
            if (dcnt_ff == '0) begin
               dneg_in = div_op[ACC_W-1];
               dq_in   = div_op[ACC_W-1] ? (ACC_W'(0) - div_op) : div_op;
               dr_in   = '0;
               dcnt_in = dcnt_ff + 1'b1;
            end else if (!div_wb) begin
               if (rem_sh >= {1'b0, div_d}) begin
                  dr_in = CNT_W'(rem_sh - {1'b0, div_d});
                  dq_in = {dq_ff[ACC_W-2:0], 1'b1};
               end else begin
                  dr_in = rem_sh[CNT_W-1:0];
                  dq_in = {dq_ff[ACC_W-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff + 1'b1;
            end else begin
               dcnt_in = '0;
               job_in  = job_ff + 1'b1;
               if (state_ff == ST_DIV_MEAN) begin
                  unique case (job_ff)
                     JM_X:    mx_in  = quo_s[31:0];
                     JM_Y:    my_in  = quo_s[31:0];
                     JM_H:    mh_in  = quo_s[15:0];
                     JM_HS:   mh2_in = quo_s[15:0];
                     default: mx_in  = mx_ff;
                  endcase
                  if (job_ff == JM_HS) begin
                     job_in  = JF_TT;
                     idx_in  = '0;
                     step_in = STEP_RD;
                     xx_in   = '0;
                     yy_in   = '0;
                     xy_in   = '0;
                     yt_in   = '0;
                     tx_in   = '0;
                     tt_in   = '0;
                     tt2_in  = '0;
                  end
               end else begin
                  unique case (job_ff)
                     JF_TT: begin
                        res_in.var_heading  = (|dq_ff[ACC_W-1:31]) ? '1 : dq_ff[30:0];
                        res_in.mean_x       = mx_ff;
                        res_in.mean_y       = my_ff;
                        res_in.mean_heading = mh_ff;
                     end
                     JF_XX:   res_in.var_x = (|dq_ff[ACC_W-1:64]) ? '1 : dq_ff[63:0];
                     JF_YY:   res_in.var_y = (|dq_ff[ACC_W-1:64]) ? '1 : dq_ff[63:0];
                     JF_XY:   res_in.cov_xy = sat_signed(dq_ff, dneg_ff, 64);
                     JF_YH:   res_in.cov_y_heading = 48'(sat_signed(dq_ff, dneg_ff, 48));
                     JF_XH:   res_in.cov_x_heading = 48'(sat_signed(dq_ff, dneg_ff, 48));
                     default: res_in = res_ff;
                  endcase
               end
            end
         end
         // walk the store: read, deviations, then multiply and accumulate
         ST_PASS1, ST_PASS2: begin
            if (step_ff == STEP_DEV) begin
               dx_in = $signed({rd_x_ff[31], rd_x_ff}) - $signed({mx_ff[31], mx_ff});
               dy_in = $signed({rd_y_ff[31], rd_y_ff}) - $signed({my_ff[31], my_ff});
               e1_in = $signed({rd_h_ff[15], rd_h_ff}) - $signed({mh_ff[15], mh_ff});
               e2_in = $signed({h_shift[15], h_shift}) - $signed({mh2_ff[15], mh2_ff});
               dh_in = rd_h_ff - mh_ff;
            end
            if (step_ff >= STEP_ACC0) begin
               if (state_ff == ST_PASS1) begin
                  unique case (acc_k)
                     K_SQ_X:  xx_in  = acc_sum;
                     K_SQ_Y:  yy_in  = acc_sum;
                     K_SQ_H:  tt_in  = acc_sum[TT_W-1:0];
                     K_SQ_HS: tt2_in = acc_sum[TT_W-1:0];
                     default: xx_in  = xx_ff;
                  endcase
               end else begin
                  unique case (acc_k)
                     K_XY:    xy_in = acc_sum;
                     K_YH:    yt_in = acc_sum;
                     K_XH:    tx_in = acc_sum;
                     default: xy_in = xy_ff;
                  endcase
               end
            end
            if (step_ff == step_last) begin
               step_in = STEP_RD;
               idx_in  = idx_ff + 1'b1;
               if (pass_end) begin
                  idx_in  = '0;
                  job_in  = JF_TT;
                  dcnt_in = '0;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         // keep the heading mean with the smaller spread
         ST_PICK: begin
            if (tt_ff > tt2_ff) begin
               tt_in = tt2_ff;
               mh_in = {~mh2_ff[15], mh2_ff[14:0]};
            end
            idx_in  = '0;
            step_in = STEP_RD;
         end
         // hand the result to the output register and empty the set
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_in   = res_ff;
               count_in = '0;
               ovf_in   = 1'b0;
               sum_x_in = '0;
               sum_y_in = '0;
               sum_h_in = '0;
               sum_s_in = '0;
            end
         end
         default: count_in = count_ff;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_h_ff     <= '0;
         sum_s_ff     <= '0;
         idx_ff       <= '0;
         step_ff      <= STEP_RD;
         job_ff       <= JM_X;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_h_ff     <= sum_h_in;
         sum_s_ff     <= sum_s_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         job_ff       <= job_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dq_ff   <= dq_in;
      dr_ff   <= dr_in;
      dneg_ff <= dneg_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mh_ff   <= mh_in;
      mh2_ff  <= mh2_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      dh_ff   <= dh_in;
      prod_ff <= prod_in;
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      xy_ff   <= xy_in;
      yt_ff   <= yt_in;
      tx_ff   <= tx_in;
      tt_ff   <= tt_in;
      tt2_ff  <= tt2_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // particle store, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         store_x_mem[count_ff[AW-1:0]] <= req_data.particle_x;
         store_y_mem[count_ff[AW-1:0]] <= req_data.particle_y;
         store_h_mem[count_ff[AW-1:0]] <= req_data.particle_heading;
      end
      if (mem_rd) begin
         rd_x_ff <= store_x_mem[idx_ff[AW-1:0]];
         rd_y_ff <= store_y_mem[idx_ff[AW-1:0]];
         rd_h_ff <= store_h_mem[idx_ff[AW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `PSPS_ASSERT(a_count_bound, count_ff <= MAX_CNT, "particle count beyond store depth")
   `PSPS_ASSERT(a_ovf_full, !ovf_ff || count_ff == MAX_CNT, "overflow flag with store not full")
   `PSPS_ASSERT(a_idx_bound, !in_pass || idx_ff < count_ff, "pass index beyond particle count")
   `PSPS_ASSERT_NEXT(a_rsp_from_finish, !rsp_valid_ff && state_ff != ST_FINISH, !rsp_valid_ff, "result beat without finish")

endmodule
